### rtl/gmm_pkg.sv
package gmm_pkg;

    localparam int unsigned MaxClusters = 16;
    localparam int unsigned MaxDims     = 1024;
    localparam int unsigned ClW         = $clog2(MaxClusters);
    localparam int unsigned DimW        = $clog2(MaxDims);
    localparam int unsigned AddrW       = ClW + DimW;
    localparam int unsigned AccW        = 48;

    localparam logic [AccW-1:0] Cap48 = {AccW{1'b1}};

    typedef enum logic [1:0] {
        OP_LOAD_MEAN = 2'd0,
        OP_LOAD_INV  = 2'd1,
        OP_LOAD_BIAS = 2'd2,
        OP_SAMPLE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_OFFSET   = 2'd0,
        CFG_STEP     = 2'd1,
        CFG_DIMS     = 2'd2,
        CFG_CLUSTERS = 2'd3
    } cfg_idx_t;

    // Table write request toward the memory block
    typedef struct packed {
        logic             mean_we;
        logic             inv_we;
        logic [AddrW-1:0] addr;
        logic [31:0]      data;
    } tbl_wr_t;

endpackage

### rtl/gmm_tables.sv
module gmm_tables
(
    input  logic                            clk,
    input  gmm_pkg::tbl_wr_t                wr,
    input  logic                            rd_en,
    input  logic [gmm_pkg::AddrW-1:0]       rd_addr,
    output logic [31:0]                     mean_q,
    output logic [31:0]                     inv_q
);

    localparam int unsigned Depth = gmm_pkg::MaxClusters * gmm_pkg::MaxDims;

    logic [31:0] mean_mem [Depth];
    logic [31:0] inv_mem  [Depth];

    always_ff @(posedge clk)
    begin
        if (wr.mean_we)
        begin
            mean_mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            mean_q <= mean_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.inv_we)
        begin
            inv_mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            inv_q <= inv_mem[rd_addr];
        end
    end

endmodule

### rtl/gmm_diagonal_cluster_classifier.sv
// Diagonal Gaussian mixture classifier. Loads use opcodes 0..2.
// A sample element walks the active clusters through one shared pipeline fed
// by the mean and inverse-variance memories, one cluster read per cycle. The
// element marked last then scans the accumulators and biases, one cluster a
// cycle, and emits the winning index and score on the master stream.
// Accumulators are flip-flops and clear at reset; table memories need no
// clearing pass.
module gmm_diagonal_cluster_classifier
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: [1:0] opcode, [5:2] cluster_index, [15:6] dim_index,
    //        [47:16] load_value, [52:48] code, zero fill to 56
    input  logic [55:0]  s_tdata,
    input  logic         s_tlast,   // last_element
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: [3:0] best_cluster, [51:4] best_score, zero fill to 56
    output logic [55:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int unsigned ClW  = gmm_pkg::ClW;
    localparam int unsigned DimW = gmm_pkg::DimW;
    localparam int unsigned AccW = gmm_pkg::AccW;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_ACC  = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] off_reg, step_reg;
    logic [10:0] dims_reg;
    logic [4:0]  ncl_reg;

    logic [AccW-1:0] acc_reg [gmm_pkg::MaxClusters];
    logic [31:0]     bias_reg [gmm_pkg::MaxClusters];
    logic [DimW-1:0] ecnt_reg;
    logic [DimW-1:0] elem_reg;
    logic            last_reg;
    logic [31:0]     x_reg;

    // issue side
    logic [ClW:0]    iss_reg;
    // pipeline valid/cluster tags: s1 mem read, s2 diff, s3 sq, s4 mult, s5 acc
    logic            v1_reg, v2_reg, v3_reg, v4_reg;
    logic [ClW-1:0]  k1_reg, k2_reg, k3_reg, k4_reg;
    logic [32:0]     mag_reg;
    logic [31:0]     inv2_reg, inv3_reg;
    logic [AccW-1:0] sq_reg;
    logic [AccW+15:0] t1_reg, t2_reg;

    logic [ClW:0]    scan_reg;
    logic [ClW-1:0]  best_reg;
    logic signed [49:0] bestv_reg;
    logic [55:0]     out_reg;

    logic [1:0]  in_op;
    logic [ClW-1:0] in_cl;
    logic [DimW-1:0] in_dm;
    logic [31:0] in_word;
    logic [4:0]  in_code;
    logic        s_fire;

    assign in_op   = s_tdata[1:0];
    assign in_cl   = s_tdata[2 +: ClW];
    assign in_dm   = s_tdata[6 +: DimW];
    assign in_word = s_tdata[47:16];
    assign in_code = s_tdata[52:48];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    logic [ClW:0]  nk;
    logic [10:0]   nd;
    always_comb
    begin
        nk = (ncl_reg == 5'd0) ? 5'd1 : (ncl_reg > 5'd16 ? 5'd16 : ncl_reg);
        nd = (dims_reg == 11'd0) ? 11'd1 : (dims_reg > 11'd1024 ? 11'd1024 : dims_reg);
    end

    // dequantize: step*code fits 37 bits
    logic [36:0]        dq_prod;
    logic signed [38:0] xw;
    logic [31:0]        xsat;
    always_comb
    begin
        dq_prod = {5'd0, step_reg} * {32'd0, in_code};
        xw = $signed({{7{off_reg[31]}}, off_reg})
           + $signed({2'b00, dq_prod});
        if (xw > 39'sd2147483647)
            xsat = 32'h7FFF_FFFF;
        else if (xw < -39'sd2147483648)
            xsat = 32'h8000_0000;
        else
            xsat = xw[31:0];
    end

    gmm_pkg::tbl_wr_t wr;
    always_comb
    begin
        wr.mean_we = s_fire && (in_op == gmm_pkg::OP_LOAD_MEAN);
        wr.inv_we  = s_fire && (in_op == gmm_pkg::OP_LOAD_INV);
        wr.addr    = {in_cl, in_dm};
        wr.data    = in_word;
    end

    logic rd_en;
    logic [31:0] mean_q, inv_q;
    assign rd_en = (state_reg == ST_ACC) && (iss_reg < nk);

    gmm_tables u_tables
    (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr ({iss_reg[ClW-1:0], elem_reg}),
        .mean_q  (mean_q),
        .inv_q   (inv_q)
    );

    logic signed [33:0] diff;
    logic [65:0]        mag2;
    logic [AccW+16:0]   tsum;
    logic [AccW-1:0]    term;
    logic [AccW:0]      asum;
    assign diff = $signed({x_reg[31], x_reg}) - $signed({mean_q[31], mean_q});
    assign mag2 = {33'd0, mag_reg} * {33'd0, mag_reg};
    always_comb
    begin
        tsum = {1'b0, t1_reg} + {17'd0, t2_reg[AccW+15:16]};
        term = (tsum > {17'd0, gmm_pkg::Cap48}) ? gmm_pkg::Cap48 : tsum[AccW-1:0];
        asum = {1'b0, acc_reg[k4_reg]} + {1'b0, term};
    end

    logic signed [49:0] score;
    assign score = $signed({{18{bias_reg[scan_reg[ClW-1:0]][31]}},
                            bias_reg[scan_reg[ClW-1:0]]})
                 - $signed({3'b000, acc_reg[scan_reg[ClW-1:0]][AccW-1:1]});

    logic pipe_busy;
    assign pipe_busy = v1_reg || v2_reg || v3_reg || v4_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_fire && in_op == gmm_pkg::OP_SAMPLE)
                         state_next = ({1'b0, ecnt_reg} < nd) ? ST_ACC
                                    : (s_tlast ? ST_SCAN : ST_IDLE);
            ST_ACC:  if (iss_reg >= nk && !pipe_busy)
                         state_next = last_reg ? ST_SCAN : ST_IDLE;
            ST_SCAN: if (scan_reg >= nk) state_next = ST_OUT;
            ST_OUT:  if (m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            off_reg   <= 32'd0;
            step_reg  <= 32'd65536;
            dims_reg  <= 11'd1024;
            ncl_reg   <= 5'd16;
            ecnt_reg  <= '0;
            elem_reg  <= '0;
            last_reg  <= 1'b0;
            iss_reg   <= '0;
            scan_reg  <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            for (int i = 0; i < gmm_pkg::MaxClusters; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    gmm_pkg::CFG_OFFSET:   off_reg  <= cfg_data;
                    gmm_pkg::CFG_STEP:     step_reg <= cfg_data;
                    gmm_pkg::CFG_DIMS:     dims_reg <= cfg_data[10:0];
                    gmm_pkg::CFG_CLUSTERS: ncl_reg  <= cfg_data[4:0];
                    default: ;
                endcase
            end
            if (s_fire && in_op == gmm_pkg::OP_SAMPLE)
            begin
                last_reg <= s_tlast;
                iss_reg  <= '0;
                scan_reg <= '0;
                // hold the dimension of this element for the table reads
                elem_reg <= ecnt_reg;
                ecnt_reg <= s_tlast ? '0 : ecnt_reg + 1'b1;
            end
            if (state_reg == ST_ACC && iss_reg < nk)
            begin
                iss_reg <= iss_reg + 1'b1;
            end
            v1_reg <= rd_en;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            if (v4_reg)
            begin
                acc_reg[k4_reg] <= asum[AccW] ? gmm_pkg::Cap48 : asum[AccW-1:0];
            end
            if (state_reg == ST_SCAN)
            begin
                scan_reg <= scan_reg + 1'b1;
            end
            if (state_reg == ST_OUT && m_tready)
            begin
                for (int i = 0; i < gmm_pkg::MaxClusters; i++)
                begin
                    acc_reg[i] <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire && in_op == gmm_pkg::OP_LOAD_BIAS)
        begin
            bias_reg[in_cl] <= in_word;
        end
        if (s_fire)
        begin
            x_reg <= xsat;
        end
        k1_reg   <= iss_reg[ClW-1:0];
        k2_reg   <= k1_reg;
        k3_reg   <= k2_reg;
        k4_reg   <= k3_reg;
        mag_reg  <= diff[33] ? 33'(-diff) : diff[32:0];
        inv2_reg <= inv_q;
        sq_reg   <= mag2[63:16];
        inv3_reg <= inv2_reg;
        t1_reg   <= sq_reg * inv3_reg[31:16];
        t2_reg   <= sq_reg * inv3_reg[15:0];
        if (state_reg == ST_SCAN && scan_reg < nk)
        begin
            if (scan_reg == '0 || score > bestv_reg)
            begin
                bestv_reg <= score;
                best_reg  <= scan_reg[ClW-1:0];
            end
        end
        if (state_reg == ST_SCAN && scan_reg >= nk)
        begin
            out_reg <= {4'd0,
                        (bestv_reg > 50'sh7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF
                        : (bestv_reg < -50'sh8000_0000_0000) ? 48'h8000_0000_0000
                        : bestv_reg[47:0],
                        best_reg};
        end
    end

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = out_reg;

`ifndef SYNTHESIS
    a_out_only_scan: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_SCAN))
        else $error("result without scan");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("input taken while busy");
    a_pipe_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !pipe_busy)
        else $error("scan before pipeline drained");
`endif

endmodule
